### hdl/r5b_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// r5b_pkg - shared definitions for the radix-5 DFT butterfly
// Default sizes, Q0.31 coefficient seeds and the per-stage tag type.
// ----------------------------------------------------------------------------
package r5b_pkg;

    localparam int SAMPLE_BITS_DEF    = 16;
    localparam int COEF_FRAC_BITS_DEF = 15;

    // Q0.31 seeds: 0.559017, 0.951057, 0.25, 0.587785
    localparam logic [31:0] K31_C1 = 32'd1200479854;
    localparam logic [31:0] K31_C2 = 32'd2042378317;
    localparam logic [31:0] K31_C3 = 32'd536870912;
    localparam logic [31:0] K31_C4 = 32'd1262259218;

    // Round a Q0.31 seed to frac bits, halves up.
    function automatic logic [31:0] coef_q(input logic [31:0] k31, input int frac);
        return ((k31 >> (30 - frac)) + 32'd1) >> 1;
    endfunction

    // Control that travels with each beat down the pipeline.
    typedef struct packed {
        logic valid;
        logic inv;
        logic last;
    } tag_t;

endpackage
`default_nettype wire

### hdl/r5b_sample_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// r5b_sample_if - input channel
// Five complex samples and the last flag, valid/ready handshake.
// ----------------------------------------------------------------------------
interface r5b_sample_if #(
    parameter int SAMPLE_BITS = r5b_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] x0_re;
    logic signed [SAMPLE_BITS-1:0] x0_im;
    logic signed [SAMPLE_BITS-1:0] x1_re;
    logic signed [SAMPLE_BITS-1:0] x1_im;
    logic signed [SAMPLE_BITS-1:0] x2_re;
    logic signed [SAMPLE_BITS-1:0] x2_im;
    logic signed [SAMPLE_BITS-1:0] x3_re;
    logic signed [SAMPLE_BITS-1:0] x3_im;
    logic signed [SAMPLE_BITS-1:0] x4_re;
    logic signed [SAMPLE_BITS-1:0] x4_im;
    logic                          last_in;

    modport source (
        output valid, x0_re, x0_im, x1_re, x1_im, x2_re, x2_im,
               x3_re, x3_im, x4_re, x4_im, last_in,
        input  ready
    );
    modport sink (
        input  valid, x0_re, x0_im, x1_re, x1_im, x2_re, x2_im,
               x3_re, x3_im, x4_re, x4_im, last_in,
        output ready
    );
endinterface
`default_nettype wire

### hdl/r5b_spectrum_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// r5b_spectrum_if - output channel
// Five complex DFT bins (SAMPLE_BITS + 3 bits) and the last flag.
// ----------------------------------------------------------------------------
interface r5b_spectrum_if #(
    parameter int SAMPLE_BITS = r5b_pkg::SAMPLE_BITS_DEF
);
    logic                            valid;
    logic                            ready;
    logic signed [SAMPLE_BITS+2:0]   y0_re;
    logic signed [SAMPLE_BITS+2:0]   y0_im;
    logic signed [SAMPLE_BITS+2:0]   y1_re;
    logic signed [SAMPLE_BITS+2:0]   y1_im;
    logic signed [SAMPLE_BITS+2:0]   y2_re;
    logic signed [SAMPLE_BITS+2:0]   y2_im;
    logic signed [SAMPLE_BITS+2:0]   y3_re;
    logic signed [SAMPLE_BITS+2:0]   y3_im;
    logic signed [SAMPLE_BITS+2:0]   y4_re;
    logic signed [SAMPLE_BITS+2:0]   y4_im;
    logic                            last_out;

    modport source (
        output valid, y0_re, y0_im, y1_re, y1_im, y2_re, y2_im,
               y3_re, y3_im, y4_re, y4_im, last_out,
        input  ready
    );
    modport sink (
        input  valid, y0_re, y0_im, y1_re, y1_im, y2_re, y2_im,
               y3_re, y3_im, y4_re, y4_im, last_out,
        output ready
    );
endinterface
`default_nettype wire

### hdl/r5b_cfg_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// r5b_cfg_if - configuration write channel
// Carries the inverse register bit, valid/ready handshake.
// ----------------------------------------------------------------------------
interface r5b_cfg_if;
    logic valid;
    logic ready;
    logic inverse;

    modport source (output valid, inverse, input ready);
    modport sink   (input valid, inverse, output ready);
endinterface
`default_nettype wire

### hdl/r5b_presum.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// r5b_presum - stage 1
// Optional re/im swap, then the sum and difference terms of the butterfly.
// ----------------------------------------------------------------------------
module r5b_presum #(
    parameter int SAMPLE_BITS = r5b_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  r5b_pkg::tag_t                 tag_in,
    input  logic signed [SAMPLE_BITS-1:0] xr [5],
    input  logic signed [SAMPLE_BITS-1:0] xi [5],
    output r5b_pkg::tag_t                 tag_out,
    output logic signed [SAMPLE_BITS-1:0] r0,
    output logic signed [SAMPLE_BITS-1:0] m0,
    output logic signed [SAMPLE_BITS+1:0] sr,
    output logic signed [SAMPLE_BITS+1:0] si,
    output logic signed [SAMPLE_BITS+1:0] ur,
    output logic signed [SAMPLE_BITS+1:0] ui,
    output logic signed [SAMPLE_BITS:0]   d41r,
    output logic signed [SAMPLE_BITS:0]   d41i,
    output logic signed [SAMPLE_BITS:0]   d32r,
    output logic signed [SAMPLE_BITS:0]   d32i
);
    localparam int S1 = SAMPLE_BITS + 1;
    localparam int S2 = SAMPLE_BITS + 2;

    logic signed [SAMPLE_BITS-1:0] r [5];
    logic signed [SAMPLE_BITS-1:0] m [5];
    logic signed [S1-1:0] s14r, s23r, s14i, s23i;
    logic signed [S2-1:0] sr_next, si_next, ur_next, ui_next;
    logic signed [S1-1:0] d41r_next, d41i_next, d32r_next, d32i_next;

    r5b_pkg::tag_t                 tag_reg;
    logic signed [SAMPLE_BITS-1:0] r0_reg, m0_reg;
    logic signed [S2-1:0]          sr_reg, si_reg, ur_reg, ui_reg;
    logic signed [S1-1:0]          d41r_reg, d41i_reg, d32r_reg, d32i_reg;

    always_comb
    begin
        for (int k = 0; k < 5; k++)
        begin
            r[k] = tag_in.inv ? xi[k] : xr[k];
            m[k] = tag_in.inv ? xr[k] : xi[k];
        end
    end

    assign s14r      = S1'(r[1]) + S1'(r[4]);
    assign s23r      = S1'(r[2]) + S1'(r[3]);
    assign s14i      = S1'(m[1]) + S1'(m[4]);
    assign s23i      = S1'(m[2]) + S1'(m[3]);
    assign sr_next   = S2'(s14r) + S2'(s23r);
    assign si_next   = S2'(s14i) + S2'(s23i);
    assign ur_next   = S2'(s14r) - S2'(s23r);
    assign ui_next   = S2'(s14i) - S2'(s23i);
    assign d41r_next = S1'(r[4]) - S1'(r[1]);
    assign d41i_next = S1'(m[4]) - S1'(m[1]);
    assign d32r_next = S1'(r[3]) - S1'(r[2]);
    assign d32i_next = S1'(m[3]) - S1'(m[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '0;
        end
        else if (en)
        begin
            tag_reg <= tag_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r0_reg   <= r[0];
            m0_reg   <= m[0];
            sr_reg   <= sr_next;
            si_reg   <= si_next;
            ur_reg   <= ur_next;
            ui_reg   <= ui_next;
            d41r_reg <= d41r_next;
            d41i_reg <= d41i_next;
            d32r_reg <= d32r_next;
            d32i_reg <= d32i_next;
        end
    end

    assign tag_out = tag_reg;
    assign r0      = r0_reg;
    assign m0      = m0_reg;
    assign sr      = sr_reg;
    assign si      = si_reg;
    assign ur      = ur_reg;
    assign ui      = ui_reg;
    assign d41r    = d41r_reg;
    assign d41i    = d41i_reg;
    assign d32r    = d32r_reg;
    assign d32i    = d32i_reg;
endmodule
`default_nettype wire

### hdl/r5b_qmul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// r5b_qmul - constant coefficient multiplier
// Signed data times a positive Qx.FRAC coefficient, rounded half up, registered.
// ----------------------------------------------------------------------------
module r5b_qmul #(
    parameter int               A_BITS    = r5b_pkg::SAMPLE_BITS_DEF + 2,
    parameter int               FRAC_BITS = r5b_pkg::COEF_FRAC_BITS_DEF,
    parameter logic [FRAC_BITS:0] COEF    = '0
) (
    input  logic                                  clk,
    input  logic                                  en,
    input  logic signed [A_BITS-1:0]              a,
    output logic signed [A_BITS:0]                q
);
    localparam int P = A_BITS + FRAC_BITS + 1;
    localparam logic signed [P-1:0] RND = P'(1) << (FRAC_BITS - 1);

    logic signed [P-1:0] a_ext;
    logic signed [P-1:0] c_ext;
    logic signed [P-1:0] prod;
    logic signed [P-1:0] rnd;
    logic signed [A_BITS:0] q_reg;

    assign a_ext = P'(a);
    assign c_ext = P'(COEF);
    assign prod  = a_ext * c_ext;
    assign rnd   = prod + RND;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg <= rnd[P-1:FRAC_BITS];
        end
    end

    assign q = q_reg;
endmodule
`default_nettype wire

### hdl/r5b_rotate.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// r5b_rotate - stage 2
// The twelve coefficient products, plus bin 0 which needs no multiply.
// ----------------------------------------------------------------------------
module r5b_rotate #(
    parameter int SAMPLE_BITS    = r5b_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_FRAC_BITS = r5b_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  r5b_pkg::tag_t                 tag_in,
    input  logic signed [SAMPLE_BITS-1:0] r0,
    input  logic signed [SAMPLE_BITS-1:0] m0,
    input  logic signed [SAMPLE_BITS+1:0] sr,
    input  logic signed [SAMPLE_BITS+1:0] si,
    input  logic signed [SAMPLE_BITS+1:0] ur,
    input  logic signed [SAMPLE_BITS+1:0] ui,
    input  logic signed [SAMPLE_BITS:0]   d41r,
    input  logic signed [SAMPLE_BITS:0]   d41i,
    input  logic signed [SAMPLE_BITS:0]   d32r,
    input  logic signed [SAMPLE_BITS:0]   d32i,
    output r5b_pkg::tag_t                 tag_out,
    output logic signed [SAMPLE_BITS-1:0] r0_out,
    output logic signed [SAMPLE_BITS-1:0] m0_out,
    output logic signed [SAMPLE_BITS+2:0] y0r,
    output logic signed [SAMPLE_BITS+2:0] y0i,
    output logic signed [SAMPLE_BITS+2:0] qsr,
    output logic signed [SAMPLE_BITS+2:0] qsi,
    output logic signed [SAMPLE_BITS+2:0] qur,
    output logic signed [SAMPLE_BITS+2:0] qui,
    output logic signed [SAMPLE_BITS+1:0] d41r_c2,
    output logic signed [SAMPLE_BITS+1:0] d41r_c4,
    output logic signed [SAMPLE_BITS+1:0] d32r_c2,
    output logic signed [SAMPLE_BITS+1:0] d32r_c4,
    output logic signed [SAMPLE_BITS+1:0] d41i_c2,
    output logic signed [SAMPLE_BITS+1:0] d41i_c4,
    output logic signed [SAMPLE_BITS+1:0] d32i_c2,
    output logic signed [SAMPLE_BITS+1:0] d32i_c4
);
    localparam int CB = COEF_FRAC_BITS + 1;
    localparam int S2 = SAMPLE_BITS + 2;
    localparam int S3 = SAMPLE_BITS + 3;
    localparam logic [CB-1:0] C1 = CB'(r5b_pkg::coef_q(r5b_pkg::K31_C1, COEF_FRAC_BITS));
    localparam logic [CB-1:0] C2 = CB'(r5b_pkg::coef_q(r5b_pkg::K31_C2, COEF_FRAC_BITS));
    localparam logic [CB-1:0] C3 = CB'(r5b_pkg::coef_q(r5b_pkg::K31_C3, COEF_FRAC_BITS));
    localparam logic [CB-1:0] C4 = CB'(r5b_pkg::coef_q(r5b_pkg::K31_C4, COEF_FRAC_BITS));

    r5b_pkg::tag_t                 tag_reg;
    logic signed [SAMPLE_BITS-1:0] r0_reg, m0_reg;
    logic signed [S3-1:0]          y0r_reg, y0i_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '0;
        end
        else if (en)
        begin
            tag_reg <= tag_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r0_reg  <= r0;
            m0_reg  <= m0;
            y0r_reg <= S3'(r0) + S3'(sr);
            y0i_reg <= S3'(m0) + S3'(si);
        end
    end

    // sums times 0.25 and differences-of-sums times 0.559
    r5b_qmul #(.A_BITS(S2), .FRAC_BITS(COEF_FRAC_BITS), .COEF(C3)) u_qsr
        (.clk(clk), .en(en), .a(sr), .q(qsr));
    r5b_qmul #(.A_BITS(S2), .FRAC_BITS(COEF_FRAC_BITS), .COEF(C3)) u_qsi
        (.clk(clk), .en(en), .a(si), .q(qsi));
    r5b_qmul #(.A_BITS(S2), .FRAC_BITS(COEF_FRAC_BITS), .COEF(C1)) u_qur
        (.clk(clk), .en(en), .a(ur), .q(qur));
    r5b_qmul #(.A_BITS(S2), .FRAC_BITS(COEF_FRAC_BITS), .COEF(C1)) u_qui
        (.clk(clk), .en(en), .a(ui), .q(qui));

    // rotation terms (sine coefficients)
    r5b_qmul #(.A_BITS(S2 - 1), .FRAC_BITS(COEF_FRAC_BITS), .COEF(C2)) u_d41r_c2
        (.clk(clk), .en(en), .a(d41r), .q(d41r_c2));
    r5b_qmul #(.A_BITS(S2 - 1), .FRAC_BITS(COEF_FRAC_BITS), .COEF(C4)) u_d41r_c4
        (.clk(clk), .en(en), .a(d41r), .q(d41r_c4));
    r5b_qmul #(.A_BITS(S2 - 1), .FRAC_BITS(COEF_FRAC_BITS), .COEF(C2)) u_d32r_c2
        (.clk(clk), .en(en), .a(d32r), .q(d32r_c2));
    r5b_qmul #(.A_BITS(S2 - 1), .FRAC_BITS(COEF_FRAC_BITS), .COEF(C4)) u_d32r_c4
        (.clk(clk), .en(en), .a(d32r), .q(d32r_c4));
    r5b_qmul #(.A_BITS(S2 - 1), .FRAC_BITS(COEF_FRAC_BITS), .COEF(C2)) u_d41i_c2
        (.clk(clk), .en(en), .a(d41i), .q(d41i_c2));
    r5b_qmul #(.A_BITS(S2 - 1), .FRAC_BITS(COEF_FRAC_BITS), .COEF(C4)) u_d41i_c4
        (.clk(clk), .en(en), .a(d41i), .q(d41i_c4));
    r5b_qmul #(.A_BITS(S2 - 1), .FRAC_BITS(COEF_FRAC_BITS), .COEF(C2)) u_d32i_c2
        (.clk(clk), .en(en), .a(d32i), .q(d32i_c2));
    r5b_qmul #(.A_BITS(S2 - 1), .FRAC_BITS(COEF_FRAC_BITS), .COEF(C4)) u_d32i_c4
        (.clk(clk), .en(en), .a(d32i), .q(d32i_c4));

    assign tag_out = tag_reg;
    assign r0_out  = r0_reg;
    assign m0_out  = m0_reg;
    assign y0r     = y0r_reg;
    assign y0i     = y0i_reg;
endmodule
`default_nettype wire

### hdl/r5b_combine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// r5b_combine - stage 3
// Builds the cosine parts (a) and the sine parts (p) of bins 1 to 4.
// ----------------------------------------------------------------------------
module r5b_combine #(
    parameter int SAMPLE_BITS = r5b_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  r5b_pkg::tag_t                 tag_in,
    input  logic signed [SAMPLE_BITS-1:0] r0,
    input  logic signed [SAMPLE_BITS-1:0] m0,
    input  logic signed [SAMPLE_BITS+2:0] y0r,
    input  logic signed [SAMPLE_BITS+2:0] y0i,
    input  logic signed [SAMPLE_BITS+2:0] qsr,
    input  logic signed [SAMPLE_BITS+2:0] qsi,
    input  logic signed [SAMPLE_BITS+2:0] qur,
    input  logic signed [SAMPLE_BITS+2:0] qui,
    input  logic signed [SAMPLE_BITS+1:0] d41r_c2,
    input  logic signed [SAMPLE_BITS+1:0] d41r_c4,
    input  logic signed [SAMPLE_BITS+1:0] d32r_c2,
    input  logic signed [SAMPLE_BITS+1:0] d32r_c4,
    input  logic signed [SAMPLE_BITS+1:0] d41i_c2,
    input  logic signed [SAMPLE_BITS+1:0] d41i_c4,
    input  logic signed [SAMPLE_BITS+1:0] d32i_c2,
    input  logic signed [SAMPLE_BITS+1:0] d32i_c4,
    output r5b_pkg::tag_t                 tag_out,
    output logic signed [SAMPLE_BITS+2:0] y0r_out,
    output logic signed [SAMPLE_BITS+2:0] y0i_out,
    output logic signed [SAMPLE_BITS+4:0] ar1,
    output logic signed [SAMPLE_BITS+4:0] ai1,
    output logic signed [SAMPLE_BITS+4:0] ar2,
    output logic signed [SAMPLE_BITS+4:0] ai2,
    output logic signed [SAMPLE_BITS+4:0] pr1,
    output logic signed [SAMPLE_BITS+4:0] pi1,
    output logic signed [SAMPLE_BITS+4:0] pr2,
    output logic signed [SAMPLE_BITS+4:0] pi2
);
    localparam int W  = SAMPLE_BITS + 5;
    localparam int S3 = SAMPLE_BITS + 3;

    logic signed [W-1:0] br, bi;
    r5b_pkg::tag_t       tag_reg;
    logic signed [S3-1:0] y0r_reg, y0i_reg;
    logic signed [W-1:0] ar1_reg, ai1_reg, ar2_reg, ai2_reg;
    logic signed [W-1:0] pr1_reg, pi1_reg, pr2_reg, pi2_reg;

    assign br = W'(r0) - W'(qsr);
    assign bi = W'(m0) - W'(qsi);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '0;
        end
        else if (en)
        begin
            tag_reg <= tag_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            y0r_reg <= y0r;
            y0i_reg <= y0i;
            ar1_reg <= br + W'(qur);
            ai1_reg <= bi + W'(qui);
            ar2_reg <= br - W'(qur);
            ai2_reg <= bi - W'(qui);
            pr1_reg <= W'(d41i_c2) + W'(d32i_c4);
            pi1_reg <= W'(d41r_c2) + W'(d32r_c4);
            pr2_reg <= W'(d41i_c4) - W'(d32i_c2);
            pi2_reg <= W'(d41r_c4) - W'(d32r_c2);
        end
    end

    assign tag_out = tag_reg;
    assign y0r_out = y0r_reg;
    assign y0i_out = y0i_reg;
    assign ar1     = ar1_reg;
    assign ai1     = ai1_reg;
    assign ar2     = ar2_reg;
    assign ai2     = ai2_reg;
    assign pr1     = pr1_reg;
    assign pi1     = pi1_reg;
    assign pr2     = pr2_reg;
    assign pi2     = pi2_reg;
endmodule
`default_nettype wire

### hdl/r5b_finish.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// r5b_finish - stage 4 and output register
// Final add/sub for bins 1 to 4, saturation, re/im swap back.
// ----------------------------------------------------------------------------
module r5b_finish #(
    parameter int SAMPLE_BITS = r5b_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  r5b_pkg::tag_t                 tag_in,
    input  logic signed [SAMPLE_BITS+2:0] y0r,
    input  logic signed [SAMPLE_BITS+2:0] y0i,
    input  logic signed [SAMPLE_BITS+4:0] ar1,
    input  logic signed [SAMPLE_BITS+4:0] ai1,
    input  logic signed [SAMPLE_BITS+4:0] ar2,
    input  logic signed [SAMPLE_BITS+4:0] ai2,
    input  logic signed [SAMPLE_BITS+4:0] pr1,
    input  logic signed [SAMPLE_BITS+4:0] pi1,
    input  logic signed [SAMPLE_BITS+4:0] pr2,
    input  logic signed [SAMPLE_BITS+4:0] pi2,
    output r5b_pkg::tag_t                 tag_out,
    output logic signed [SAMPLE_BITS+2:0] yre [5],
    output logic signed [SAMPLE_BITS+2:0] yim [5]
);
    localparam int W  = SAMPLE_BITS + 5;
    localparam int OB = SAMPLE_BITS + 3;
    localparam logic signed [W-1:0] SAT_HI = {{(W - OB + 1){1'b0}}, {(OB - 1){1'b1}}};
    localparam logic signed [W-1:0] SAT_LO = {{(W - OB + 1){1'b1}}, {(OB - 1){1'b0}}};

    function automatic logic signed [OB-1:0] sat(input logic signed [W-1:0] v);
        logic signed [W-1:0] c;
        c = v;
        if (v > SAT_HI)
        begin
            c = SAT_HI;
        end
        else if (v < SAT_LO)
        begin
            c = SAT_LO;
        end
        return c[OB-1:0];
    endfunction

    logic signed [W-1:0]  vr [5];
    logic signed [W-1:0]  vi [5];
    logic signed [OB-1:0] yre_next [5];
    logic signed [OB-1:0] yim_next [5];

    r5b_pkg::tag_t        tag_reg;
    logic signed [OB-1:0] yre_reg [5];
    logic signed [OB-1:0] yim_reg [5];

    always_comb
    begin
        vr[0] = W'(y0r);
        vi[0] = W'(y0i);
        vr[1] = ar1 - pr1;
        vi[1] = ai1 + pi1;
        vr[4] = ar1 + pr1;
        vi[4] = ai1 - pi1;
        vr[2] = ar2 - pr2;
        vi[2] = ai2 + pi2;
        vr[3] = ar2 + pr2;
        vi[3] = ai2 - pi2;
        for (int k = 0; k < 5; k++)
        begin
            yre_next[k] = tag_in.inv ? sat(vi[k]) : sat(vr[k]);
            yim_next[k] = tag_in.inv ? sat(vr[k]) : sat(vi[k]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '0;
        end
        else if (en)
        begin
            tag_reg <= tag_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            yre_reg <= yre_next;
            yim_reg <= yim_next;
        end
    end

    assign tag_out = tag_reg;
    assign yre     = yre_reg;
    assign yim     = yim_reg;
endmodule
`default_nettype wire

### hdl/radix5_dft_butterfly.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// radix5_dft_butterfly - streaming 5-point DFT butterfly
//
// samples  : sink channel, five complex points x0..x4 plus last_in per beat.
// spectrum : source channel, five complex bins y0..y4 (SAMPLE_BITS + 3 bits,
//            saturated) plus last_out, a copy of last_in.
// cfg      : write channel for the inverse bit; always ready. Bit set swaps
//            re/im on the way in and out, giving an unscaled inverse DFT.
//            Write it only while the pipe is empty.
// Pipeline : four register stages (pre-sums, coefficient multiply, partial
//            combine, final add/saturate into the output register). A beat
//            moves through them in that order and is presented on spectrum
//            from the output register until spectrum.ready takes it.
// Rate     : one beat per cycle; each stage moves when its successor is empty
//            or moving, so bubbles collapse and a stalled output holds the
//            pipe without dropping or repeating a beat. samples.ready falls
//            only once all four stages are full and spectrum.ready is low.
// Reset    : rst_n clears all stage valid bits and the inverse bit.
// ----------------------------------------------------------------------------
module radix5_dft_butterfly #(
    parameter int SAMPLE_BITS    = r5b_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_FRAC_BITS = r5b_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    r5b_sample_if.sink     samples,
    r5b_spectrum_if.source spectrum,
    r5b_cfg_if.sink        cfg
);
    localparam int SB = SAMPLE_BITS;

    // config register
    logic inverse_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inverse_reg <= 1'b0;
        end
        else if (cfg.valid)
        begin
            inverse_reg <= cfg.inverse;
        end
    end

    assign cfg.ready = 1'b1;

    // stage enables: a stage loads when it is empty or its successor loads
    r5b_pkg::tag_t tag0, tag1, tag2, tag3, tag4;
    logic en1, en2, en3, en4;

    assign en4 = !tag4.valid || spectrum.ready;
    assign en3 = !tag3.valid || en4;
    assign en2 = !tag2.valid || en3;
    assign en1 = !tag1.valid || en2;

    assign samples.ready = en1;

    assign tag0.valid = samples.valid;
    assign tag0.inv   = inverse_reg;
    assign tag0.last  = samples.last_in;

    // input unpack
    logic signed [SB-1:0] xr [5];
    logic signed [SB-1:0] xi [5];

    always_comb
    begin
        xr[0] = samples.x0_re;
        xi[0] = samples.x0_im;
        xr[1] = samples.x1_re;
        xi[1] = samples.x1_im;
        xr[2] = samples.x2_re;
        xi[2] = samples.x2_im;
        xr[3] = samples.x3_re;
        xi[3] = samples.x3_im;
        xr[4] = samples.x4_re;
        xi[4] = samples.x4_im;
    end

    // stage 1: pre-sums
    logic signed [SB-1:0] s1_r0, s1_m0;
    logic signed [SB+1:0] s1_sr, s1_si, s1_ur, s1_ui;
    logic signed [SB:0]   s1_d41r, s1_d41i, s1_d32r, s1_d32i;

    r5b_presum #(.SAMPLE_BITS(SB)) u_presum (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en1),
        .tag_in  (tag0),
        .xr      (xr),
        .xi      (xi),
        .tag_out (tag1),
        .r0      (s1_r0),
        .m0      (s1_m0),
        .sr      (s1_sr),
        .si      (s1_si),
        .ur      (s1_ur),
        .ui      (s1_ui),
        .d41r    (s1_d41r),
        .d41i    (s1_d41i),
        .d32r    (s1_d32r),
        .d32i    (s1_d32i)
    );

    // stage 2: constant multipliers
    logic signed [SB-1:0] s2_r0, s2_m0;
    logic signed [SB+2:0] s2_y0r, s2_y0i, s2_qsr, s2_qsi, s2_qur, s2_qui;
    logic signed [SB+1:0] s2_d41r_c2, s2_d41r_c4, s2_d32r_c2, s2_d32r_c4;
    logic signed [SB+1:0] s2_d41i_c2, s2_d41i_c4, s2_d32i_c2, s2_d32i_c4;

    r5b_rotate #(.SAMPLE_BITS(SB), .COEF_FRAC_BITS(COEF_FRAC_BITS)) u_rotate (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en2),
        .tag_in  (tag1),
        .r0      (s1_r0),
        .m0      (s1_m0),
        .sr      (s1_sr),
        .si      (s1_si),
        .ur      (s1_ur),
        .ui      (s1_ui),
        .d41r    (s1_d41r),
        .d41i    (s1_d41i),
        .d32r    (s1_d32r),
        .d32i    (s1_d32i),
        .tag_out (tag2),
        .r0_out  (s2_r0),
        .m0_out  (s2_m0),
        .y0r     (s2_y0r),
        .y0i     (s2_y0i),
        .qsr     (s2_qsr),
        .qsi     (s2_qsi),
        .qur     (s2_qur),
        .qui     (s2_qui),
        .d41r_c2 (s2_d41r_c2),
        .d41r_c4 (s2_d41r_c4),
        .d32r_c2 (s2_d32r_c2),
        .d32r_c4 (s2_d32r_c4),
        .d41i_c2 (s2_d41i_c2),
        .d41i_c4 (s2_d41i_c4),
        .d32i_c2 (s2_d32i_c2),
        .d32i_c4 (s2_d32i_c4)
    );

    // stage 3: cosine and sine partials
    logic signed [SB+2:0] s3_y0r, s3_y0i;
    logic signed [SB+4:0] s3_ar1, s3_ai1, s3_ar2, s3_ai2;
    logic signed [SB+4:0] s3_pr1, s3_pi1, s3_pr2, s3_pi2;

    r5b_combine #(.SAMPLE_BITS(SB)) u_combine (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en3),
        .tag_in  (tag2),
        .r0      (s2_r0),
        .m0      (s2_m0),
        .y0r     (s2_y0r),
        .y0i     (s2_y0i),
        .qsr     (s2_qsr),
        .qsi     (s2_qsi),
        .qur     (s2_qur),
        .qui     (s2_qui),
        .d41r_c2 (s2_d41r_c2),
        .d41r_c4 (s2_d41r_c4),
        .d32r_c2 (s2_d32r_c2),
        .d32r_c4 (s2_d32r_c4),
        .d41i_c2 (s2_d41i_c2),
        .d41i_c4 (s2_d41i_c4),
        .d32i_c2 (s2_d32i_c2),
        .d32i_c4 (s2_d32i_c4),
        .tag_out (tag3),
        .y0r_out (s3_y0r),
        .y0i_out (s3_y0i),
        .ar1     (s3_ar1),
        .ai1     (s3_ai1),
        .ar2     (s3_ar2),
        .ai2     (s3_ai2),
        .pr1     (s3_pr1),
        .pi1     (s3_pi1),
        .pr2     (s3_pr2),
        .pi2     (s3_pi2)
    );

    // stage 4: final butterflies into the output register
    logic signed [SB+2:0] yre [5];
    logic signed [SB+2:0] yim [5];

    r5b_finish #(.SAMPLE_BITS(SB)) u_finish (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en4),
        .tag_in  (tag3),
        .y0r     (s3_y0r),
        .y0i     (s3_y0i),
        .ar1     (s3_ar1),
        .ai1     (s3_ai1),
        .ar2     (s3_ar2),
        .ai2     (s3_ai2),
        .pr1     (s3_pr1),
        .pi1     (s3_pi1),
        .pr2     (s3_pr2),
        .pi2     (s3_pi2),
        .tag_out (tag4),
        .yre     (yre),
        .yim     (yim)
    );

    assign spectrum.valid    = tag4.valid;
    assign spectrum.last_out = tag4.last;
    assign spectrum.y0_re    = yre[0];
    assign spectrum.y0_im    = yim[0];
    assign spectrum.y1_re    = yre[1];
    assign spectrum.y1_im    = yim[1];
    assign spectrum.y2_re    = yre[2];
    assign spectrum.y2_im    = yim[2];
    assign spectrum.y3_re    = yre[3];
    assign spectrum.y3_im    = yim[3];
    assign spectrum.y4_re    = yre[4];
    assign spectrum.y4_im    = yim[4];
endmodule
`default_nettype wire

### tb/radix5_dft_butterfly_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix5_dft_butterfly_tb - self-checking bench for the radix-5 butterfly
// Walks a short table of hand-picked butterflies in both directions, then streams
// random butterflies with random gaps and output stalls. Every result beat is
// compared field by field with a typed value or a bit-exact fixed-point predictor.
// ----------------------------------------------------------------------------
module radix5_dft_butterfly_tb;

    localparam int SB    = r5b_pkg::SAMPLE_BITS_DEF;
    localparam int OB    = r5b_pkg::SAMPLE_BITS_DEF + 3;
    localparam int FRAC  = r5b_pkg::COEF_FRAC_BITS_DEF;
    localparam int NDIR  = 21;
    localparam int NSEG  = 5;
    localparam int SEG_N = 230;

    // Q0.31 seeds rounded to FRAC bits, halves up (18318, 31164, 8192, 19261)
    localparam longint C_559 = longint'(((r5b_pkg::K31_C1 >> (30 - FRAC)) + 32'd1) >> 1);
    localparam longint C_951 = longint'(((r5b_pkg::K31_C2 >> (30 - FRAC)) + 32'd1) >> 1);
    localparam longint C_250 = longint'(((r5b_pkg::K31_C3 >> (30 - FRAC)) + 32'd1) >> 1);
    localparam longint C_588 = longint'(((r5b_pkg::K31_C4 >> (30 - FRAC)) + 32'd1) >> 1);

    // Five complex points in, five complex bins out; index k = point / bin k.
    typedef struct packed {
        logic [4:0][SB-1:0] re;
        logic [4:0][SB-1:0] im;
        logic               last;
    } frame_t;

    typedef struct packed {
        logic [4:0][OB-1:0] re;
        logic [4:0][OB-1:0] im;
        logic               last;
    } bins_t;

    // One row of the directed table; want is only meaningful when known is set.
    typedef struct {
        frame_t frame;
        bit     known;
        bins_t  want;
    } dir_row_t;

    logic clk;
    logic rst_n;

    r5b_sample_if   samples ();
    r5b_spectrum_if spectrum ();
    r5b_cfg_if      cfg ();

    radix5_dft_butterfly uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .samples  (samples),
        .spectrum (spectrum),
        .cfg      (cfg)
    );

    // Bench state
    bins_t    spectra_due [$];    // predicted bins, oldest first
    dir_row_t walk_table [NDIR];
    logic     inverse_q;          // bench copy of the inverse register
    bit       steady;             // when set, neither side idles
    int       n_sent;
    int       n_checked;
    int       n_errors;
    int       n_last;
    int       n_inv_beats;

    // ------------------------------------------------------------------------
    // Clock and watchdog
    // ------------------------------------------------------------------------
    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Slowest legal run is ~1200 beats with the longest gaps, stalls and pipe fill,
    // well under 200 us; this allows ten times that.
    initial
    begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // data * coef, back to integer with round-half-up (toward +inf)
    function automatic longint coef_mul(input longint a, input longint c);
        longint half;
        half = longint'(1) <<< (FRAC - 1);
        return (a * c + half) >>> FRAC;
    endfunction

    // clamp to the signed output width
    function automatic logic [OB-1:0] clip(input longint v);
        longint lim;
        lim = longint'(1) <<< (OB - 1);
        if (v > lim - 1)
            v = lim - 1;
        if (v < -lim)
            v = -lim;
        return v[OB-1:0];
    endfunction

    // 5-point DFT via sum/difference decomposition. For inverse, re and im
    // trade places going in and again coming out.
    function automatic bins_t dft5(input frame_t f, input logic inv);
        longint r [5];
        longint m [5];
        longint yr [5];
        longint yi [5];
        longint s14r, s23r, s14i, s23i, d41r, d32r, d41i, d32i;
        longint sr, si, br, bi, er, ei, ar, ai, pr, pi;
        bins_t  b;
        for (int k = 0; k < 5; k++)
        begin
            r[k] = inv ? longint'($signed(f.im[k])) : longint'($signed(f.re[k]));
            m[k] = inv ? longint'($signed(f.re[k])) : longint'($signed(f.im[k]));
        end
        s14r = r[1] + r[4];
        s23r = r[2] + r[3];
        s14i = m[1] + m[4];
        s23i = m[2] + m[3];
        d41r = r[4] - r[1];
        d32r = r[3] - r[2];
        d41i = m[4] - m[1];
        d32i = m[3] - m[2];
        sr   = s14r + s23r;
        si   = s14i + s23i;
        br   = r[0] - coef_mul(sr, C_250);
        bi   = m[0] - coef_mul(si, C_250);
        er   = coef_mul(s14r - s23r, C_559);
        ei   = coef_mul(s14i - s23i, C_559);

        yr[0] = r[0] + sr;
        yi[0] = m[0] + si;

        ar = br + er;
        ai = bi + ei;
        pr = coef_mul(d41i, C_951) + coef_mul(d32i, C_588);
        pi = coef_mul(d41r, C_951) + coef_mul(d32r, C_588);
        yr[1] = ar - pr;
        yi[1] = ai + pi;
        yr[4] = ar + pr;
        yi[4] = ai - pi;

        ar = br - er;
        ai = bi - ei;
        pr = coef_mul(d41i, C_588) - coef_mul(d32i, C_951);
        pi = coef_mul(d41r, C_588) - coef_mul(d32r, C_951);
        yr[2] = ar - pr;
        yi[2] = ai + pi;
        yr[3] = ar + pr;
        yi[3] = ai - pi;

        for (int k = 0; k < 5; k++)
        begin
            b.re[k] = inv ? clip(yi[k]) : clip(yr[k]);
            b.im[k] = inv ? clip(yr[k]) : clip(yi[k]);
        end
        b.last = f.last;
        return b;
    endfunction

    // ------------------------------------------------------------------------
    // Table helpers
    // ------------------------------------------------------------------------
    function automatic frame_t mk(input logic [SB-1:0] r0, input logic [SB-1:0] i0,
                                  input logic [SB-1:0] r1, input logic [SB-1:0] i1,
                                  input logic [SB-1:0] r2, input logic [SB-1:0] i2,
                                  input logic [SB-1:0] r3, input logic [SB-1:0] i3,
                                  input logic [SB-1:0] r4, input logic [SB-1:0] i4,
                                  input logic lst);
        frame_t f;
        f.re   = {r4, r3, r2, r1, r0};
        f.im   = {i4, i3, i2, i1, i0};
        f.last = lst;
        return f;
    endfunction

    // impulse at point 0: every bin equals x0
    function automatic bins_t flat(input int vr, input int vi, input logic lst);
        bins_t b;
        for (int k = 0; k < 5; k++)
        begin
            b.re[k] = OB'(vr);
            b.im[k] = OB'(vi);
        end
        b.last = lst;
        return b;
    endfunction

    // constant input: all energy in bin 0
    function automatic bins_t dc(input int vr, input int vi, input logic lst);
        bins_t b;
        b       = '0;
        b.re[0] = OB'(vr);
        b.im[0] = OB'(vi);
        b.last  = lst;
        return b;
    endfunction

    // Directed rows. Typed results only for point-0 impulses and constants;
    // these read the same in both directions, so the table is reused after the swap.
    initial
    begin
        // all zero, with and without last
        walk_table[0]  = '{mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0), 1'b1, dc(0, 0, 1'b0)};
        walk_table[1]  = '{mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1), 1'b1, dc(0, 0, 1'b1)};
        // impulses at point 0, field extremes and +1/-1
        walk_table[2]  = '{mk(16'h7fff, 16'h8000, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0),
                           1'b1, flat(32767, -32768, 1'b0)};
        walk_table[3]  = '{mk(16'h8000, 16'h7fff, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1),
                           1'b1, flat(-32768, 32767, 1'b1)};
        walk_table[4]  = '{mk(16'h0001, 16'hffff, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0),
                           1'b1, flat(1, -1, 1'b0)};
        // impulses at the other points
        walk_table[5]  = '{mk(0, 0, 16'h7fff, 0, 0, 0, 0, 0, 0, 0, 1'b0), 1'b0, '0};
        walk_table[6]  = '{mk(0, 0, 0, 0, 0, 16'h8000, 0, 0, 0, 0, 1'b0), 1'b0, '0};
        walk_table[7]  = '{mk(0, 0, 0, 0, 0, 0, 16'h8000, 16'h8000, 0, 0, 1'b1), 1'b0, '0};
        walk_table[8]  = '{mk(0, 0, 0, 0, 0, 0, 0, 0, 16'h7fff, 16'h7fff, 1'b0), 1'b0, '0};
        // constants at the extremes: widest bin 0
        walk_table[9]  = '{mk(16'h7fff, 0, 16'h7fff, 0, 16'h7fff, 0, 16'h7fff, 0,
                              16'h7fff, 0, 1'b0), 1'b1, dc(163835, 0, 1'b0)};
        walk_table[10] = '{mk(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                              16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b1),
                           1'b1, dc(-163840, -163840, 1'b1)};
        walk_table[11] = '{mk(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                              16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 1'b0),
                           1'b1, dc(163835, 163835, 1'b0)};
        // alternating extremes
        walk_table[12] = '{mk(16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000,
                              16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 1'b0), 1'b0, '0};
        walk_table[13] = '{mk(16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff,
                              16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 1'b1), 1'b0, '0};
        walk_table[14] = '{mk(16'h5555, 16'haaaa, 16'haaaa, 16'h5555, 16'h5555, 16'haaaa,
                              16'haaaa, 16'h5555, 16'h5555, 16'haaaa, 1'b0), 1'b0, '0};
        // small values whose total sum cancels, so the 0.25 product is zero
        walk_table[15] = '{mk(0, 0, 16'h0002, 16'hfffe, 16'h0006, 16'hfffa,
                              16'hfffe, 16'h0002, 16'hfffa, 16'h0006, 1'b0), 1'b0, '0};
        // largest s14 - s23 and largest differences d41, d32
        walk_table[16] = '{mk(0, 0, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000,
                              16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 1'b0), 1'b0, '0};
        walk_table[17] = '{mk(16'h7fff, 0, 16'h8000, 0, 16'h8000, 0,
                              16'h7fff, 0, 16'h7fff, 0, 1'b1), 1'b0, '0};
        walk_table[18] = '{mk(0, 16'h8000, 0, 16'h8000, 0, 16'h8000,
                              0, 16'h7fff, 0, 16'h7fff, 1'b0), 1'b0, '0};
        // constants of -1 and +1: rounding of the 0.25 term cancels the rest
        walk_table[19] = '{mk(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
                              16'hffff, 16'hffff, 16'hffff, 16'hffff, 1'b0),
                           1'b1, dc(-5, -5, 1'b0)};
        walk_table[20] = '{mk(16'h0001, 16'h0001, 16'h0001, 16'h0001, 16'h0001, 16'h0001,
                              16'h0001, 16'h0001, 16'h0001, 16'h0001, 1'b1),
                           1'b1, dc(5, 5, 1'b1)};
    end

    // ------------------------------------------------------------------------
    // Sample side
    // ------------------------------------------------------------------------

    // Present one butterfly and wait for its beat. Ready is read at the falling
    // edge, where everything driven at the rising edge has settled. Valid stays
    // high afterwards; the next call or park_samples() decides what follows.
    task automatic send_frame(input frame_t f, input bit known, input bins_t want);
        int gap;
        bit took;
        gap = steady ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            samples.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        samples.valid   <= 1'b1;
        samples.x0_re   <= f.re[0];
        samples.x0_im   <= f.im[0];
        samples.x1_re   <= f.re[1];
        samples.x1_im   <= f.im[1];
        samples.x2_re   <= f.re[2];
        samples.x2_im   <= f.im[2];
        samples.x3_re   <= f.re[3];
        samples.x3_im   <= f.im[3];
        samples.x4_re   <= f.re[4];
        samples.x4_im   <= f.im[4];
        samples.last_in <= f.last;
        do
        begin
            @(negedge clk);
            took = samples.ready;
            @(posedge clk);
        end
        while (!took);
        spectra_due.push_back(known ? want : dft5(f, inverse_q));
        n_sent++;
        if (f.last)
            n_last++;
        if (inverse_q)
            n_inv_beats++;
    endtask

    // Drop valid and hold off until the pipe has handed back every bin.
    task automatic park_samples();
        samples.valid <= 1'b0;
        while (spectra_due.size() != 0)
            @(posedge clk);
    endtask

    // Write the inverse bit; only ever called with the pipe empty.
    task automatic set_direction(input logic inv);
        bit took;
        park_samples();
        cfg.valid   <= 1'b1;
        cfg.inverse <= inv;
        do
        begin
            @(negedge clk);
            took = cfg.ready;
            @(posedge clk);
        end
        while (!took);
        cfg.valid <= 1'b0;
        inverse_q = inv;
    endtask

    // One sample value: extremes, tiny values near rounding halves, or anything.
    function automatic logic [SB-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 16'h7fff;
            1:       return 16'h8000;
            2:       return '0;
            3:       return 16'hffff;
            4:       return SB'($urandom_range(0, 31)) - SB'(16);
            default: return SB'($urandom);
        endcase
    endfunction

    // Random butterfly; some are constants or single impulses, which stress
    // bin 0 and the flat response, the rest are independent points.
    function automatic frame_t random_frame();
        frame_t f;
        int     shape;
        int     hot;
        logic [SB-1:0] cr, ci;
        shape = $urandom_range(0, 7);
        hot   = $urandom_range(0, 4);
        cr    = pick_value();
        ci    = pick_value();
        for (int k = 0; k < 5; k++)
        begin
            case (shape)
                0:
                begin
                    f.re[k] = cr;
                    f.im[k] = ci;
                end
                1:
                begin
                    f.re[k] = (k == hot) ? cr : '0;
                    f.im[k] = (k == hot) ? ci : '0;
                end
                default:
                begin
                    f.re[k] = pick_value();
                    f.im[k] = pick_value();
                end
            endcase
        end
        f.last = ($urandom_range(0, 3) == 0);
        return f;
    endfunction

    // ------------------------------------------------------------------------
    // Spectrum side: random stalls, snapshot at the falling edge, check after
    // the beat has been taken at the next rising edge.
    // ------------------------------------------------------------------------
    task automatic compare_bins(input bins_t seen);
        bins_t want;
        if (spectra_due.size() == 0)
        begin
            $error("spectrum beat with nothing outstanding");
            n_errors++;
            return;
        end
        want = spectra_due.pop_front();
        n_checked++;
        for (int k = 0; k < 5; k++)
        begin
            if (seen.re[k] !== want.re[k])
            begin
                $error("y%0d_re: expected %0d, got %0d", k,
                       $signed(want.re[k]), $signed(seen.re[k]));
                n_errors++;
            end
            if (seen.im[k] !== want.im[k])
            begin
                $error("y%0d_im: expected %0d, got %0d", k,
                       $signed(want.im[k]), $signed(seen.im[k]));
                n_errors++;
            end
        end
        if (seen.last !== want.last)
        begin
            $error("last_out: expected %0d, got %0d", want.last, seen.last);
            n_errors++;
        end
    endtask

    initial
    begin
        int    stall;
        bit    got;
        bins_t seen;
        spectrum.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = steady ? 0 : $urandom_range(0, 7);
            if (stall > 0)
            begin
                spectrum.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            spectrum.ready <= 1'b1;
            do
            begin
                @(negedge clk);
                got = spectrum.valid;
                if (got)
                begin
                    seen.re[0] = spectrum.y0_re;
                    seen.im[0] = spectrum.y0_im;
                    seen.re[1] = spectrum.y1_re;
                    seen.im[1] = spectrum.y1_im;
                    seen.re[2] = spectrum.y2_re;
                    seen.im[2] = spectrum.y2_im;
                    seen.re[3] = spectrum.y3_re;
                    seen.im[3] = spectrum.y3_im;
                    seen.re[4] = spectrum.y4_re;
                    seen.im[4] = spectrum.y4_im;
                    seen.last  = spectrum.last_out;
                end
                @(posedge clk);
            end
            while (!got);
            compare_bins(seen);
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        logic seg_dir [NSEG];
        int   n_dir;
        seg_dir = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
        n_dir   = 0;

        // every input known from time zero
        rst_n           = 1'b0;
        samples.valid   = 1'b0;
        samples.x0_re   = '0;
        samples.x0_im   = '0;
        samples.x1_re   = '0;
        samples.x1_im   = '0;
        samples.x2_re   = '0;
        samples.x2_im   = '0;
        samples.x3_re   = '0;
        samples.x3_im   = '0;
        samples.x4_re   = '0;
        samples.x4_im   = '0;
        samples.last_in = 1'b0;
        cfg.valid       = 1'b0;
        cfg.inverse     = 1'b0;
        inverse_q       = 1'b0;   // register clears on reset
        steady          = 1'b0;
        n_sent          = 0;
        n_checked       = 0;
        n_errors        = 0;
        n_last          = 0;
        n_inv_beats     = 0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table, first in the reset direction (forward), then inverse.
        // The second half of each pass runs back to back.
        for (int pass = 0; pass < 2; pass++)
        begin
            if (pass == 1)
                set_direction(1'b1);
            for (int i = 0; i < NDIR; i++)
            begin
                steady = (i >= NDIR / 2);
                send_frame(walk_table[i].frame, walk_table[i].known, walk_table[i].want);
                n_dir++;
            end
        end

        // Random segments; each starts with a register write on an empty pipe.
        // Within a segment every third stretch of 40 beats runs without idling.
        for (int s = 0; s < NSEG; s++)
        begin
            steady = 1'b0;
            set_direction(seg_dir[s]);
            for (int i = 0; i < SEG_N; i++)
            begin
                steady = ((i / 40) % 3 == 2);
                send_frame(random_frame(), 1'b0, '0);
            end
        end

        // drain, then give the pipe time to show any stray beat
        steady = 1'b0;
        park_samples();
        repeat (12) @(posedge clk);

        $display("Sent %0d butterflies (%0d directed, %0d inverse, %0d with last set),",
                 n_sent, n_dir, n_inv_beats, n_last);
        $display("checked %0d spectra across forward/inverse switches, %0d mismatches",
                 n_checked, n_errors);
        if (n_errors == 0 && spectra_due.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

### radix5_dft_butterfly.f
hdl/r5b_pkg.sv
hdl/r5b_sample_if.sv
hdl/r5b_spectrum_if.sv
hdl/r5b_cfg_if.sv
hdl/r5b_presum.sv
hdl/r5b_qmul.sv
hdl/r5b_rotate.sv
hdl/r5b_combine.sv
hdl/r5b_finish.sv
hdl/radix5_dft_butterfly.sv
tb/radix5_dft_butterfly_tb.sv
